/* src/slot_pool_dense_active_list_core_macros.svh */
// ----------------------------------------------------------------------------
// slot_pool_dense_active_list_core_macros
// Assertion macros for the slot pool core. Clocked on aclk, idle in reset.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_DENSE_ACTIVE_LIST_CORE_MACROS_SVH
`define SLOT_POOL_DENSE_ACTIVE_LIST_CORE_MACROS_SVH

// consequent checked in the same cycle
`define SPDAL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SPDAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/spdal_pkg.sv */
// ----------------------------------------------------------------------------
// spdal_pkg
// Shared widths and codes of the slot pool core.
// ----------------------------------------------------------------------------
package spdal_pkg;

    localparam int POOL_SLOTS_DEF = 1024;

    localparam int FUNC_W   = 2;
    localparam int HANDLE_W = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int POS_W    = 10;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = STATUS_W;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ACTIVE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_POSITION = 2'd3;

endpackage

/* src/slot_pool_dense_active_list_core.sv */
// ----------------------------------------------------------------------------
// slot_pool_dense_active_list_core
// Slot handle pool: free stack, dense active list and per-handle position map.
// ----------------------------------------------------------------------------
// One item is handled at a time; s_tready is high only while the core is idle.
// The result register is loaded from ST_ALLOC, ST_LOOKUP or ST_REPLY for
// allocate, look-up, pool full and the unused selector, and from ST_REL_CHK,
// after ST_REL_RD, for any release; the core is idle again from that edge.
// The three RAMs have registered read data, so a release reads the position
// map, then reads the dense list at that position before it commits. A result
// waiting on m_tready holds the core in its final step. The free stack needs no
// clearing pass after reset: a low-water mark marks entries never pushed, which
// read as their own index.
module slot_pool_dense_active_list_core #(
    parameter int POOL_SLOTS = spdal_pkg::POOL_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [9:0] slot, [19:10] position, [23:20] zero
    input  logic [spdal_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [spdal_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [9:0] handle, [20:10] active_count, [30:21] dense_pos, [31] zero
    output logic [spdal_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [spdal_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = $clog2(POOL_SLOTS + 1);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_ALLOC   = 6'b000010,
        ST_REL_RD  = 6'b000100,
        ST_REL_CHK = 6'b001000,
        ST_LOOKUP  = 6'b010000,
        ST_REPLY   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] free_top_reg, free_top_next;
    logic [CW-1:0] low_water_reg, low_water_next;
    logic [CW-1:0] active_total_reg, active_total_next;

    logic [spdal_pkg::POS_W-1:0]    slot_reg, position_reg;
    logic                           slot_ok_reg;
    logic [AW-1:0]                  last_reg;
    logic [spdal_pkg::HANDLE_W-1:0] res_handle_reg;
    logic [spdal_pkg::STATUS_W-1:0] res_status_reg;

    logic                           m_tvalid_reg;
    logic [spdal_pkg::HANDLE_W-1:0] m_handle_reg, m_handle_next;
    logic [spdal_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [spdal_pkg::COUNT_W-1:0]  m_count_reg, m_count_next;
    logic [spdal_pkg::POS_W-1:0]    m_pos_reg, m_pos_next;

    logic [spdal_pkg::FUNC_W-1:0] s_func;
    logic [spdal_pkg::POS_W-1:0]  s_slot, s_position;
    logic accept, out_free, finish;
    logic commit_alloc, commit_rel, rel_ok, rel_move;
    logic [AW-1:0] alloc_h;

    logic          fs_we, al_we, sp_we;
    logic [AW-1:0] fs_waddr, al_waddr, sp_waddr;
    logic [AW-1:0] fs_wdata, al_wdata, sp_wdata;
    logic [AW-1:0] fs_raddr, al_raddr, sp_raddr;
    logic [AW-1:0] fs_rdata, al_rdata, sp_rdata;

    assign s_func     = s_tuser[1:0];
    assign s_slot     = s_tdata[9:0];
    assign s_position = s_tdata[19:10];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Entries at or above the low-water mark were pushed before being read again.
    assign alloc_h = (free_top_reg == low_water_reg) ? AW'(free_top_reg - CW'(1)) : fs_rdata;

    assign rel_ok   = slot_ok_reg && (CW'(sp_rdata) < active_total_reg)
                      && (al_rdata == AW'(slot_reg));
    assign rel_move = (CW'(sp_rdata) + CW'(1)) != active_total_reg;

    assign commit_alloc = (state_reg == ST_ALLOC) && out_free;
    assign commit_rel   = (state_reg == ST_REL_CHK) && out_free && rel_ok;

    // RAM ports
    assign fs_raddr = AW'(free_top_reg - CW'(1));
    assign fs_we    = commit_rel;
    assign fs_waddr = AW'(free_top_reg);
    assign fs_wdata = AW'(slot_reg);

    assign sp_raddr = (state_reg == ST_IDLE) ? AW'(s_slot) : AW'(slot_reg);
    assign sp_we    = commit_alloc || (commit_rel && rel_move);
    assign sp_waddr = commit_alloc ? alloc_h : last_reg;
    assign sp_wdata = commit_alloc ? AW'(active_total_reg) : sp_rdata;

    assign al_we    = commit_alloc || (commit_rel && rel_move);
    assign al_waddr = commit_alloc ? AW'(active_total_reg) : sp_rdata;
    assign al_wdata = commit_alloc ? alloc_h : last_reg;

    always_comb begin
        al_raddr = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_func == spdal_pkg::FUNC_RELEASE) begin
                    al_raddr = AW'(active_total_reg - CW'(1));
                end else begin
                    al_raddr = AW'(s_position);
                end
            end
            ST_REL_RD, ST_REL_CHK: al_raddr = sp_rdata;
            ST_LOOKUP:             al_raddr = AW'(position_reg);
            ST_ALLOC, ST_REPLY:    al_raddr = '0;
            default:               al_raddr = '0;
        endcase
    end

    spdal_ram #(.DEPTH(POOL_SLOTS), .WIDTH(AW), .AW(AW)) u_free_stack (
        .aclk(aclk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .raddr(fs_raddr), .rdata(fs_rdata)
    );

    spdal_ram #(.DEPTH(POOL_SLOTS), .WIDTH(AW), .AW(AW)) u_active_list (
        .aclk(aclk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
        .raddr(al_raddr), .rdata(al_rdata)
    );

    spdal_ram #(.DEPTH(POOL_SLOTS), .WIDTH(AW), .AW(AW)) u_slot_position (
        .aclk(aclk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
        .raddr(sp_raddr), .rdata(sp_rdata)
    );

    always_comb begin
        state_next        = state_reg;
        free_top_next     = free_top_reg;
        low_water_next    = low_water_reg;
        active_total_next = active_total_reg;
        finish            = 1'b0;
        m_handle_next     = m_handle_reg;
        m_status_next     = m_status_reg;
        m_count_next      = m_count_reg;
        m_pos_next        = m_pos_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        spdal_pkg::FUNC_ALLOC: begin
                            state_next = (free_top_reg == '0) ? ST_REPLY : ST_ALLOC;
                        end
                        spdal_pkg::FUNC_RELEASE: state_next = ST_REL_RD;
                        spdal_pkg::FUNC_LOOKUP: begin
                            if (32'(s_position) < 32'(active_total_reg)) begin
                                state_next = ST_LOOKUP;
                            end else begin
                                state_next = ST_REPLY;
                            end
                        end
                        default: state_next = ST_REPLY;
                    endcase
                end
            end
            ST_ALLOC: begin
                if (out_free) begin
                    finish            = 1'b1;
                    state_next        = ST_IDLE;
                    free_top_next     = free_top_reg - CW'(1);
                    active_total_next = active_total_reg + CW'(1);
                    if (free_top_reg == low_water_reg) begin
                        low_water_next = free_top_reg - CW'(1);
                    end
                    m_handle_next = spdal_pkg::HANDLE_W'(alloc_h);
                    m_status_next = spdal_pkg::STATUS_OK;
                    m_count_next  = spdal_pkg::COUNT_W'(active_total_reg + CW'(1));
                    m_pos_next    = spdal_pkg::POS_W'(active_total_reg);
                end
            end
            ST_REL_RD: state_next = ST_REL_CHK;
            ST_REL_CHK: begin
                if (out_free) begin
                    finish        = 1'b1;
                    state_next    = ST_IDLE;
                    m_handle_next = slot_reg;
                    if (rel_ok) begin
                        free_top_next     = free_top_reg + CW'(1);
                        active_total_next = active_total_reg - CW'(1);
                        m_status_next     = spdal_pkg::STATUS_OK;
                        m_count_next      = spdal_pkg::COUNT_W'(active_total_reg - CW'(1));
                        m_pos_next        = spdal_pkg::POS_W'(sp_rdata);
                    end else begin
                        m_status_next = spdal_pkg::STATUS_NOT_ACTIVE;
                        m_count_next  = spdal_pkg::COUNT_W'(active_total_reg);
                        m_pos_next    = '0;
                    end
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    finish        = 1'b1;
                    state_next    = ST_IDLE;
                    m_handle_next = spdal_pkg::HANDLE_W'(al_rdata);
                    m_status_next = spdal_pkg::STATUS_OK;
                    m_count_next  = spdal_pkg::COUNT_W'(active_total_reg);
                    m_pos_next    = position_reg;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    finish        = 1'b1;
                    state_next    = ST_IDLE;
                    m_handle_next = res_handle_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = spdal_pkg::COUNT_W'(active_total_reg);
                    m_pos_next    = '0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            free_top_reg     <= CW'(POOL_SLOTS);
            low_water_reg    <= CW'(POOL_SLOTS);
            active_total_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            free_top_reg     <= free_top_next;
            low_water_reg    <= low_water_next;
            active_total_reg <= active_total_next;
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg     <= s_slot;
            position_reg <= s_position;
            slot_ok_reg  <= 32'(s_slot) < 32'(POOL_SLOTS);
            res_handle_reg <= '0;
            case (s_func)
                spdal_pkg::FUNC_ALLOC:  res_status_reg <= spdal_pkg::STATUS_FULL;
                spdal_pkg::FUNC_LOOKUP: res_status_reg <= spdal_pkg::STATUS_NO_POSITION;
                default:                res_status_reg <= spdal_pkg::STATUS_OK;
            endcase
        end
        if (state_reg == ST_REL_RD) begin
            last_reg <= al_rdata;
        end
        m_handle_reg <= m_handle_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
        m_pos_reg    <= m_pos_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_pos_reg, m_count_reg, m_handle_reg};
    assign m_tuser  = m_status_reg;

    `include "slot_pool_dense_active_list_core_macros.svh"

    `SPDAL_ASSERT_SAME(a_pool_balance, 1'b1,
        (32'(free_top_reg) + 32'(active_total_reg) == 32'(POOL_SLOTS)),
        "free and active counts do not add up to the pool size")
    `SPDAL_ASSERT_SAME(a_low_water, 1'b1, (low_water_reg <= free_top_reg),
        "free stack top below its low-water mark")
    `SPDAL_ASSERT_NEXT(a_accept_busy, accept, (state_reg != ST_IDLE),
        "item accepted but core stayed idle")
    `SPDAL_ASSERT_NEXT(a_alloc_count, commit_alloc,
        (active_total_reg == $past(active_total_reg) + CW'(1)),
        "allocate did not grow the active list")

endmodule

/* src/spdal_ram.sv */
// ----------------------------------------------------------------------------
// spdal_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module spdal_ram #(
    parameter int DEPTH = spdal_pkg::POOL_SLOTS_DEF,
    parameter int WIDTH = $clog2(spdal_pkg::POOL_SLOTS_DEF),
    parameter int AW    = $clog2(spdal_pkg::POOL_SLOTS_DEF)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for slot_pool_dense_active_list_core. A behavioural
// copy of the pool (free stack, dense list, position map) predicts every
// result as each item is accepted. Directed cases cover the empty pool,
// swap-remove, double release, an out-of-range look-up and the unused
// selector. A fill to the full pool follows, then a hold-off on the result
// side and random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS          = spdal_pkg::POOL_SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF       = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_ITEMS   = 125;

    localparam logic [spdal_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [spdal_pkg::HANDLE_W-1:0] handle;
        logic [spdal_pkg::STATUS_W-1:0] status;
        logic [spdal_pkg::COUNT_W-1:0]  count;
        logic [spdal_pkg::POS_W-1:0]    dense_pos;
    } pool_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    // [9:0] slot, [19:10] position, [23:20] zero
    logic [spdal_pkg::S_TDATA_W-1:0] s_tdata;
    // [1:0] func
    logic [spdal_pkg::S_TUSER_W-1:0] s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    // [9:0] handle, [20:10] active_count, [30:21] dense_pos, [31] zero
    logic [spdal_pkg::M_TDATA_W-1:0] m_tdata;
    // [1:0] status
    logic [spdal_pkg::M_TUSER_W-1:0] m_tuser;

    slot_pool_dense_active_list_core #(
        .POOL_SLOTS(SLOTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // pool shadow
    logic [spdal_pkg::HANDLE_W-1:0] free_handles [SLOTS];
    logic [spdal_pkg::HANDLE_W-1:0] dense_list   [SLOTS];
    logic [spdal_pkg::POS_W-1:0]    handle_pos   [SLOTS];
    bit                             ever_used    [SLOTS];
    int                             used_handles [$];
    int                             free_depth;
    int                             live_count;

    pool_result_t expected_results [$];
    pool_result_t got_result;
    pool_result_t want_result;

    int fail_count;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;
    int idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic pool_result_t pool_apply(
        input logic [spdal_pkg::FUNC_W-1:0] func,
        input logic [spdal_pkg::HANDLE_W-1:0] slot,
        input logic [spdal_pkg::POS_W-1:0] position);
        pool_result_t                   r;
        int                             p;
        logic [spdal_pkg::HANDLE_W-1:0] h;
        logic [spdal_pkg::HANDLE_W-1:0] last;
        r = '0;
        case (func)
            spdal_pkg::FUNC_ALLOC: begin
                if (free_depth == 0 || live_count >= SLOTS) begin
                    r.status = spdal_pkg::STATUS_FULL;
                end else begin
                    free_depth--;
                    h = free_handles[free_depth];
                    dense_list[live_count] = h;
                    handle_pos[h] = spdal_pkg::POS_W'(live_count);
                    if (!ever_used[h]) begin
                        ever_used[h] = 1'b1;
                        used_handles.insert(used_handles.size(), int'(h));
                    end
                    live_count++;
                    r.handle    = h;
                    r.status    = spdal_pkg::STATUS_OK;
                    r.dense_pos = spdal_pkg::POS_W'(live_count - 1);
                end
            end
            spdal_pkg::FUNC_RELEASE: begin
                r.handle = slot;
                p = ever_used[slot] ? int'(handle_pos[slot]) : SLOTS;
                if (p >= live_count || dense_list[p] != slot) begin
                    r.status = spdal_pkg::STATUS_NOT_ACTIVE;
                end else begin
                    last = dense_list[live_count - 1];
                    if (p + 1 != live_count) begin
                        dense_list[p]    = last;
                        handle_pos[last] = spdal_pkg::POS_W'(p);
                    end
                    live_count--;
                    if (free_depth < SLOTS) begin
                        free_handles[free_depth] = slot;
                        free_depth++;
                    end
                    r.status    = spdal_pkg::STATUS_OK;
                    r.dense_pos = spdal_pkg::POS_W'(p);
                end
            end
            spdal_pkg::FUNC_LOOKUP: begin
                if (position >= live_count) begin
                    r.status = spdal_pkg::STATUS_NO_POSITION;
                end else begin
                    r.handle    = dense_list[position];
                    r.status    = spdal_pkg::STATUS_OK;
                    r.dense_pos = position;
                end
            end
            default: begin
                r.status = spdal_pkg::STATUS_OK;
            end
        endcase
        r.count = spdal_pkg::COUNT_W'(live_count);
        return r;
    endfunction

    task automatic pool_clear();
        for (int i = 0; i < SLOTS; i++) begin
            free_handles[i] = spdal_pkg::HANDLE_W'(i);
            ever_used[i]    = 1'b0;
        end
        used_handles.delete();
        free_depth = SLOTS;
        live_count = 0;
    endtask

    task automatic send_op(input logic [spdal_pkg::FUNC_W-1:0] func,
                           input int slot,
                           input int position);
        logic [spdal_pkg::HANDLE_W-1:0] slot_bits;
        logic [spdal_pkg::POS_W-1:0]    pos_bits;
        slot_bits = spdal_pkg::HANDLE_W'(slot);
        pos_bits  = spdal_pkg::POS_W'(position);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, pos_bits, slot_bits};
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        expected_results.insert(expected_results.size(),
                                pool_apply(func, slot_bits, pos_bits));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    task automatic release_any_active();
        send_op(spdal_pkg::FUNC_RELEASE, dense_list[$urandom_range(live_count - 1)], $urandom);
    endtask

    // result side: random stalls, or a counted hold-off when requested
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.handle    = m_tdata[spdal_pkg::HANDLE_W-1:0];
            got_result.count     = m_tdata[spdal_pkg::HANDLE_W +: spdal_pkg::COUNT_W];
            got_result.dense_pos =
                m_tdata[spdal_pkg::HANDLE_W + spdal_pkg::COUNT_W +: spdal_pkg::POS_W];
            got_result.status    = m_tuser;
            if (expected_results.size() == 0) begin
                fail_count++;
                $error("result with nothing expected: handle %0d", got_result.handle);
            end else begin
                want_result = expected_results.pop_front();
                check_field("handle", want_result.handle, got_result.handle);
                check_field("status", want_result.status, got_result.status);
                check_field("active_count", want_result.count, got_result.count);
                check_field("dense_pos", want_result.dense_pos, got_result.dense_pos);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic test_empty_pool();
        send_op(spdal_pkg::FUNC_LOOKUP, $urandom, '0);
        send_op(spdal_pkg::FUNC_LOOKUP, $urandom, '1);
        send_op(FUNC_UNUSED, '1, '1);
    endtask

    task automatic test_alloc_lookup();
        repeat (4) send_op(spdal_pkg::FUNC_ALLOC, $urandom, $urandom);
        send_op(spdal_pkg::FUNC_LOOKUP, '0, '0);
        send_op(spdal_pkg::FUNC_LOOKUP, '1, 10'd3);
        send_op(spdal_pkg::FUNC_LOOKUP, $urandom, 10'd4);
        send_op(spdal_pkg::FUNC_LOOKUP, $urandom, '1);
    endtask

    // handles come off the free stack from the top: SLOTS-1 first
    task automatic test_release_cases();
        send_op(spdal_pkg::FUNC_RELEASE, SLOTS - 2, $urandom);   // middle, last one swapped in
        send_op(spdal_pkg::FUNC_LOOKUP, $urandom, 10'd1);
        send_op(spdal_pkg::FUNC_RELEASE, SLOTS - 3, $urandom);   // last position, no move
        send_op(spdal_pkg::FUNC_RELEASE, SLOTS - 2, $urandom);   // double release, stale map
        send_op(spdal_pkg::FUNC_RELEASE, SLOTS - 3, $urandom);   // map past the count
        send_op(spdal_pkg::FUNC_RELEASE, SLOTS - 1, $urandom);   // head of the list
        send_op(spdal_pkg::FUNC_RELEASE, SLOTS - 4, $urandom);   // empties the pool
        send_op(spdal_pkg::FUNC_RELEASE, SLOTS - 4, $urandom);   // release on empty pool
        send_op(spdal_pkg::FUNC_LOOKUP, $urandom, '0);
        send_op(spdal_pkg::FUNC_ALLOC, $urandom, $urandom);
        send_op(FUNC_UNUSED, '0, '0);
    endtask

    task automatic test_fill_and_drain();
        set_idling(0, 0);
        while (live_count < SLOTS) send_op(spdal_pkg::FUNC_ALLOC, $urandom, $urandom);
        send_op(spdal_pkg::FUNC_ALLOC, $urandom, $urandom);
        send_op(spdal_pkg::FUNC_ALLOC, '1, '1);
        send_op(spdal_pkg::FUNC_LOOKUP, $urandom, '1);
        send_op(spdal_pkg::FUNC_LOOKUP, $urandom, '0);
        send_op(spdal_pkg::FUNC_RELEASE, '0, $urandom);
        send_op(spdal_pkg::FUNC_RELEASE, '1, $urandom);
        send_op(spdal_pkg::FUNC_ALLOC, $urandom, $urandom);
        set_idling(38, 38);
        while (live_count > SLOTS / 2) release_any_active();
        send_op(spdal_pkg::FUNC_RELEASE, '0, $urandom);
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        wait_drained();
        hold_cycles = HOLD_OFF;
        repeat (6) send_op(spdal_pkg::FUNC_ALLOC, $urandom, $urandom);
        repeat (6) send_op(spdal_pkg::FUNC_LOOKUP, $urandom, $urandom_range(7));
        wait_drained();
    endtask

    task automatic test_random(input int n_items, input int send_pct, input int recv_pct);
        int alloc_pct;
        int pick;
        set_idling(send_pct, recv_pct);
        for (int i = 0; i < n_items; i++) begin
            // swing the fill level up and down
            alloc_pct = ((i / 100) % 2 == 0) ? 55 : 25;
            pick = $urandom_range(99);
            if (pick < alloc_pct) begin
                send_op(spdal_pkg::FUNC_ALLOC, $urandom, $urandom);
            end else if (pick < alloc_pct + 35 && used_handles.size() != 0) begin
                if (live_count > 0 && $urandom_range(99) < 80)
                    release_any_active();
                else
                    send_op(spdal_pkg::FUNC_RELEASE,
                            used_handles[$urandom_range(used_handles.size() - 1)],
                            $urandom);
            end else if (pick < 95) begin
                if (live_count == 0 || $urandom_range(3) == 0)
                    send_op(spdal_pkg::FUNC_LOOKUP, $urandom, $urandom);
                else
                    send_op(spdal_pkg::FUNC_LOOKUP, $urandom, $urandom_range(live_count - 1));
            end else begin
                send_op(FUNC_UNUSED, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        m_tready    <= 1'b0;
        fail_count  = 0;
        hold_cycles = 0;
        idle_cycles = 0;
        set_idling(0, 0);
        pool_clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_pool();
        test_alloc_lookup();
        test_release_cases();
        test_fill_and_drain();
        test_backpressure();
        test_random(RANDOM_ITEMS, 0, 0);
        test_random(RANDOM_ITEMS, 80, 0);
        test_random(RANDOM_ITEMS, 0, 80);
        test_random(RANDOM_ITEMS, 38, 38);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
